@@ hdl/stgen_pkg.sv @@
// Shared constants, types and the quarter-wave sine table of the tone generator.
package stgen_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int TABLE_BITS   = 10;
  localparam int PHASE_BITS   = 32;

  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;
  localparam int AMPLITUDE    = 16000;
  localparam int MAG_W        = 14;
  localparam int SAMPLE_W     = 15;
  localparam int FRAME_W      = 12;
  localparam int CNT_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int IDX_OUT_W    = 3;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam logic [1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [1:0] REG_FRAME_LENGTH  = 2'd2;

  localparam logic [31:0] PHASE_STEP_RESET    = 32'd39370534;
  localparam logic [3:0]  CHANNEL_COUNT_RESET = 4'd1;
  localparam logic [11:0] FRAME_LENGTH_RESET  = 12'd480;

  // pi/2 in Q60
  localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

  typedef struct packed {
    logic [31:0] phase_step;
    logic [3:0]  channel_count;
    logic [11:0] frame_length;
  } cfg_t;

  typedef struct packed {
    logic [TABLE_BITS-1:0] idx;
    logic                  eof;
    logic [CNT_W-1:0]      last_ch;
  } lookup_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                eof;
    logic [CNT_W-1:0]    last_ch;
  } emit_t;

  typedef logic [QUARTER-1:0][MAG_W-1:0] mag_rom_t;

  // (a*b) >> 60, low 64 bits kept
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // unsigned 64-bit quotient by shift and subtract; elaboration only
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // floor(16000*sin(pi/2 * m / QUARTER)), Taylor series in Q60; elaboration only
  function automatic logic [MAG_W-1:0] sine_magnitude(input logic [QUARTER_BITS:0] m);
    logic [63:0] frac_mask;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] d;
    if (m == '0) return '0;
    if (int'(m) >= QUARTER) return MAG_W'(AMPLITUDE);
    frac_mask = (64'd1 << QUARTER_BITS) - 64'd1;
    x = (HALF_PI_Q60 >> QUARTER_BITS) * 64'(m)
        + (((HALF_PI_Q60 & frac_mask) * 64'(m)) >> QUARTER_BITS);
    x2 = mul_q60(x, x);
    term = x;
    sum = x;
    for (int n = 1; n <= 14; n++) begin
      d = 64'(2 * n) * 64'(2 * n + 1);
      term = div_u64(mul_q60(term, x2), d);
      if (n % 2 == 1) sum = sum - term;
      else sum = sum + term;
    end
    return MAG_W'(mul_q60(sum, 64'(AMPLITUDE)));
  endfunction

  function automatic mag_rom_t build_mag();
    mag_rom_t t;
    for (int i = 0; i < QUARTER; i++) begin
      t[i] = sine_magnitude((QUARTER_BITS + 1)'(i));
    end
    return t;
  endfunction

  localparam mag_rom_t MAG_ROM = build_mag();

endpackage

@@ hdl/stgen_cfg.sv @@
// APB register file: phase step, channel count, frame length.
module stgen_cfg
  import stgen_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr;
  logic [1:0] sel;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign sel    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_step    <= PHASE_STEP_RESET;
      cfg.channel_count <= CHANNEL_COUNT_RESET;
      cfg.frame_length  <= FRAME_LENGTH_RESET;
    end else if (wr) begin
      unique case (sel)
        REG_PHASE_STEP:    cfg.phase_step    <= pwdata;
        REG_CHANNEL_COUNT: cfg.channel_count <= pwdata[3:0];
        REG_FRAME_LENGTH:  cfg.frame_length  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PHASE_STEP:    prdata = cfg.phase_step;
      REG_CHANNEL_COUNT: prdata = {28'd0, cfg.channel_count};
      REG_FRAME_LENGTH:  prdata = {20'd0, cfg.frame_length};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ hdl/stgen_phase.sv @@
// Phase accumulator and frame position; registers table index and marks per tick.
module stgen_phase
  import stgen_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    restart,
  output logic    out_valid,
  input  logic    out_ready,
  output lookup_t out_item
);

  logic [PHASE_BITS-1:0] phase;
  logic [FRAME_W-1:0]    frame_pos;
  logic [PHASE_BITS-1:0] phase_base;
  logic [FRAME_W-1:0]    pos_base;
  logic [PHASE_BITS-1:0] phase_next;
  logic [FRAME_W-1:0]    frame_pos_next;
  logic [FRAME_W:0]      pos_plus;
  logic [FRAME_W-1:0]    flen;
  logic                  eof;
  logic [CNT_W-1:0]      last_ch;
  logic                  take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign phase_base = restart ? '0 : phase;
  assign pos_base   = restart ? '0 : frame_pos;
  assign phase_next = phase_base + PHASE_BITS'(cfg.phase_step);

  assign flen           = (cfg.frame_length == '0) ? FRAME_W'(1) : cfg.frame_length;
  assign pos_plus       = {1'b0, pos_base} + (FRAME_W + 1)'(1);
  assign eof            = pos_plus >= {1'b0, flen};
  assign frame_pos_next = eof ? '0 : pos_plus[FRAME_W-1:0];

  // clamp channel count to 1..MAX_CHANNELS, keep index of final copy
  always_comb begin
    if (cfg.channel_count == '0) begin
      last_ch = '0;
    end else if (int'(cfg.channel_count) > MAX_CHANNELS) begin
      last_ch = CNT_W'(MAX_CHANNELS - 1);
    end else begin
      last_ch = CNT_W'(cfg.channel_count - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      frame_pos <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        frame_pos <= frame_pos_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.idx     <= phase_base[PHASE_BITS-1 -: TABLE_BITS];
      out_item.eof     <= eof;
      out_item.last_ch <= last_ch;
    end
  end

endmodule

@@ hdl/stgen_lookup.sv @@
// Quarter-wave sine lookup with sign fold; registers the sample.
module stgen_lookup
  import stgen_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  lookup_t in_item,
  output logic    out_valid,
  input  logic    out_ready,
  output emit_t   out_item
);

  logic [1:0]                 quad;
  logic [QUARTER_BITS-1:0]    r;
  logic [QUARTER_BITS:0]      m;
  logic [MAG_W-1:0]           mag;
  logic signed [SAMPLE_W-1:0] pos_val;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       take;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign quad = in_item.idx[TABLE_BITS-1 -: 2];
  assign r    = in_item.idx[QUARTER_BITS-1:0];
  // odd quadrants run backwards through the table
  assign m    = quad[0] ? ((QUARTER_BITS + 1)'(QUARTER) - {1'b0, r}) : {1'b0, r};
  assign mag  = m[QUARTER_BITS] ? MAG_W'(AMPLITUDE) : MAG_ROM[m[QUARTER_BITS-1:0]];

  assign pos_val = $signed({1'b0, mag});
  assign sample  = quad[1] ? -pos_val : pos_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item.sample  <= sample;
      out_item.eof     <= in_item.eof;
      out_item.last_ch <= in_item.last_ch;
    end
  end

endmodule

@@ hdl/stgen_fanout.sv @@
// Output register that repeats each sample once per channel.
module stgen_fanout
  import stgen_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  emit_t                in_item,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [SAMPLE_W-1:0]  sample,
  output logic [IDX_OUT_W-1:0] channel_index,
  output logic                 last_of_item,
  output logic                 end_of_frame
);

  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] last_ch;
  logic             last;
  logic             load;

  assign last     = cnt == last_ch;
  assign in_ready = !m_tvalid || (m_tready && last);
  assign load     = in_valid && in_ready;

  assign channel_index = IDX_OUT_W'(cnt);
  assign last_of_item  = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      cnt      <= '0;
    end else if (m_tvalid && m_tready) begin
      if (last) begin
        m_tvalid <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sample       <= in_item.sample;
      end_of_frame <= in_item.eof;
      last_ch      <= in_item.last_ch;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt <= last_ch)
    else $error("channel counter past final channel");

  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !last |=> m_tvalid && cnt == CNT_W'($past(cnt) + 1'b1))
    else $error("channel copy skipped or repeated");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && last && !in_valid |=> !m_tvalid)
    else $error("output stayed valid after final copy");

endmodule

@@ hdl/sine_tone_frame_generator.sv @@
// Top level of the DDS sine tone generator with per-channel frame output.
//
//  channel  | dir | transfer                 | payload
//  ---------+-----+--------------------------+----------------------------------------
//  s_axis   | in  | s_tvalid && s_tready     | s_tdata[0] restart
//  m_axis   | out | m_tvalid && m_tready     | tdata sample/channel, tlast, tuser eof
//  apb      | in  | psel&penable&pwrite      | 0x0 phase_step, 0x4 channels, 0x8 frame
//
// Three register stages: phase/frame update, sine table read, channel fanout.
// A tick passes the phase register, then the sine table register, then the fanout
// register, which emits one copy per cycle while m_tready is high, so a tick gives
// channel_count copies (zero as one, above MAX_CHANNELS as MAX_CHANNELS) and the
// copies of successive ticks follow back to back when the sink never stalls.
// Reset (synchronous, rst high) zeroes phase and frame position, empties all
// stages and loads the register defaults; the sine table is constant logic.
// A stall on m_tready backs up through the stages; s_tready drops only when all
// three stages are full.
module sine_tone_frame_generator
  import stgen_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // slave stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // [0] restart, [7:1] zero
  // master stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,   // [14:0] sample, [17:15] channel_index, [23:18] zero
  output logic              m_tlast,   // last_of_item
  output logic              m_tuser,   // end_of_frame
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  lookup_t lk_item;
  emit_t   em_item;
  logic    lk_valid;
  logic    lk_ready;
  logic    em_valid;
  logic    em_ready;

  logic [SAMPLE_W-1:0]  sample;
  logic [IDX_OUT_W-1:0] channel_index;

  stgen_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // tick in: restart applied before the table index is taken
  stgen_phase u_phase (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .restart   (s_tdata[0]),
    .out_valid (lk_valid),
    .out_ready (lk_ready),
    .out_item  (lk_item)
  );

  stgen_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lk_valid),
    .in_ready  (lk_ready),
    .in_item   (lk_item),
    .out_valid (em_valid),
    .out_ready (em_ready),
    .out_item  (em_item)
  );

  stgen_fanout u_fanout (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (em_valid),
    .in_ready      (em_ready),
    .in_item       (em_item),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .sample        (sample),
    .channel_index (channel_index),
    .last_of_item  (m_tlast),
    .end_of_frame  (m_tuser)
  );

  assign m_tdata = {6'd0, channel_index, sample};

endmodule

@@ test/sine_tone_frame_generator_tb.sv @@
// Self-checking testbench for the sine tone frame generator: stream ticks in, channel copies out.
`timescale 1ns / 100ps

module sine_tone_frame_generator_tb;
  import stgen_pkg::*;

  // Table geometry used by the predictor's own copy of the sine table
  localparam int TAB_SIZE  = 1 << TABLE_BITS;
  localparam int QTR_SHIFT = TABLE_BITS - 2;
  localparam int QTR       = 1 << QTR_SHIFT;
  localparam int PEAK      = 16000;

  // One channel copy of a sample as it should leave the block
  typedef struct packed {
    logic [14:0] sample;
    logic [2:0]  chan;
    logic        last;
    logic        eof;
  } chan_copy_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [23:0]       m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  sine_tone_frame_generator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the block hangs on a handshake
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: phase accumulator, frame position and register shadows
  // ---------------------------------------------------------------------------
  logic [14:0] sine_tab [0:TAB_SIZE-1];
  logic [31:0] phase_acc;
  logic [11:0] frame_pos;
  logic [31:0] step_reg;
  logic [3:0]  chan_reg;
  logic [11:0] flen_reg;

  chan_copy_t  pending_copies[$];

  int          errors;
  int          ticks_sent;
  int          copies_checked;
  int          reg_writes;
  int          restarts_sent;
  bit          idle_en;    // random idling on both sides
  int          hold_req;   // sink hold-off request, in cycles

  // (a*b) >> 60 over the full 128-bit product
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return 64'(prod >> 60);
  endfunction

  // floor(16000*sin(pi/2 * m/QTR)), odd Taylor terms in Q60
  function automatic int quarter_sine(input int m);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    if (m == 0) return 0;
    if (m >= QTR) return PEAK;
    x = (HALF_PI_Q60 >> QTR_SHIFT) * 64'(m)
        + (((HALF_PI_Q60 & 64'(QTR - 1)) * 64'(m)) >> QTR_SHIFT);
    x2 = fx_mul(x, x);
    term = x;
    acc = x;
    for (int n = 1; n <= 14; n++) begin
      term = fx_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
      acc = n[0] ? acc - term : acc + term;
    end
    return int'(fx_mul(acc, 64'(PEAK)));
  endfunction

  // Full-wave table from the quarter wave, stored as 15-bit two's complement
  task automatic fill_sine_table();
    int quad;
    int off;
    int mag;
    for (int i = 0; i < TAB_SIZE; i++) begin
      quad = i >> QTR_SHIFT;
      off  = i & (QTR - 1);
      mag  = quarter_sine(quad[0] ? QTR - off : off);
      sine_tab[i] = quad[1] ? 15'(-mag) : 15'(mag);
    end
  endtask

  // Expected copies of one accepted tick. The table is read at the old phase,
  // then the phase advances; the frame mark comes from the position count.
  task automatic predict_tick(input logic restart);
    logic [11:0] flen;
    logic [12:0] next_pos;
    logic [3:0]  nchan;
    logic        eof;
    logic [14:0] smp;
    chan_copy_t  c;
    if (restart) begin
      phase_acc = '0;
      frame_pos = '0;
    end
    smp = sine_tab[phase_acc[PHASE_BITS-1 -: TABLE_BITS]];
    phase_acc = phase_acc + step_reg;
    // zero length acts as one; a length below the position ends the frame now
    flen = (flen_reg == '0) ? 12'd1 : flen_reg;
    next_pos = {1'b0, frame_pos} + 13'd1;
    eof = next_pos >= {1'b0, flen};
    frame_pos = eof ? 12'd0 : next_pos[11:0];
    // zero channels acts as one, above the limit saturates
    if (chan_reg == '0) nchan = 4'd1;
    else if (chan_reg > 4'(MAX_CHANNELS)) nchan = 4'(MAX_CHANNELS);
    else nchan = chan_reg;
    for (int k = 0; k < nchan; k++) begin
      c.sample = smp;
      c.chan   = 3'(k);
      c.last   = (k + 1 == nchan);
      c.eof    = eof;
      pending_copies.push_back(c);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls, plus a counted hold-off on request
  // ---------------------------------------------------------------------------
  int hold_left;
  initial hold_left = 0;
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      m_tready  = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready = !(idle_en && ($urandom_range(99) < 13));
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: every transfer against the oldest expected copy
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    chan_copy_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_copies.size() == 0) begin
        $display("%0t ns: unexpected output transfer, expected none, actual tdata 0x%0h",
                 $time, m_tdata);
        errors++;
      end else begin
        want = pending_copies.pop_front();
        check_field("sample", want.sample, m_tdata[14:0]);
        check_field("channel_index", want.chan, m_tdata[17:15]);
        check_field("tdata padding", 0, m_tdata[23:18]);
        check_field("last_of_item", want.last, m_tlast);
        check_field("end_of_frame", want.eof, m_tuser);
        copies_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers. All of them are entered and left just after a falling edge.
  // ---------------------------------------------------------------------------

  // One tick on the slave stream; random gaps before it when idling is on.
  // tvalid stays high across back-to-back ticks.
  task automatic send_tick(input logic restart);
    while (idle_en && ($urandom_range(99) < 13)) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, restart};
    do @(posedge clk); while (!s_tready);
    predict_tick(restart);
    ticks_sent++;
    if (restart) restarts_sent++;
    @(negedge clk);
  endtask

  // Sender pauses until every expected copy has come out
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending_copies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle completing when pready is high
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PHASE_STEP:    step_reg = value;
      REG_CHANNEL_COUNT: chan_reg = value[3:0];
      REG_FRAME_LENGTH:  flen_reg = value[11:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Registers change only with the pipeline empty
  task automatic configure(input logic [31:0] step, input logic [3:0] nchan,
                           input logic [11:0] flen);
    wait_drained();
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_CHANNEL_COUNT, {28'd0, nchan});
    write_reg(REG_FRAME_LENGTH, {20'd0, flen});
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Register defaults straight out of reset, then a restart mid-stream
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Quarter-turn step hits exact 0, +peak, 0, -peak; every tick ends a frame.
  // Then zero channels and zero frame length, both acting as one.
  task automatic test_quarter_points();
    configure(32'h4000_0000, 4'd8, 12'd1);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    configure(32'h4000_0000, 4'd0, 12'd0);
    repeat (3) send_tick(1'b0);
  endtask

  // Channel count above the limit saturates; extreme phase steps
  task automatic test_channel_limits();
    configure(32'hFFFF_FFFF, 4'd15, 12'd3);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    configure(32'h0000_0000, 4'd9, 12'd2);
    repeat (2) send_tick(1'b0);
  endtask

  // Frame length cut below the current position: next tick closes the frame
  task automatic test_frame_shrink();
    configure(32'h0123_4567, 4'd2, 12'd4095);
    send_tick(1'b1);
    repeat (7) send_tick(1'b0);
    configure(32'h0123_4567, 4'd2, 12'd4);
    repeat (3) send_tick(1'b0);
  endtask

  // Sink holds off for a long stretch while ticks keep coming, so the stages
  // fill and s_tready has to drop; afterwards the sender waits for the drain.
  task automatic test_backpressure();
    configure($urandom(), 4'd8, 12'd7);
    idle_en  = 1'b0;
    hold_req = 200;
    repeat (30) send_tick(1'b0);
    wait_drained();
    idle_en = 1'b1;
    repeat (10) send_tick($urandom_range(99) < 6);
  endtask

  // Random settings per phase; the first phase runs with no idling at all
  task automatic test_random_settings();
    logic [31:0] step;
    logic [3:0]  nchan;
    logic [11:0] flen;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(3))
        0: step = $urandom_range(1, 1 << 20);
        default: step = $urandom();
      endcase
      nchan = ($urandom_range(8) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8));
      case ($urandom_range(4))
        0: flen = 12'($urandom_range(1, 4));
        1: flen = 12'($urandom_range(5, 40));
        2: flen = 12'($urandom_range(4095));
        3: flen = 12'd0;
        default: flen = 12'd4095;
      endcase
      if (ph == 0) begin
        step  = 32'hFFFF_FFFF;
        nchan = 4'd8;
        flen  = 12'd4095;
      end else if (ph == 1) begin
        step  = 32'd0;
        nchan = 4'd1;
        flen  = 12'd1;
      end
      configure(step, nchan, flen);
      idle_en = (ph != 0);
      repeat (75) send_tick($urandom_range(99) < 6);
    end
    idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'd0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    errors         = 0;
    ticks_sent     = 0;
    copies_checked = 0;
    reg_writes     = 0;
    restarts_sent  = 0;
    idle_en        = 1'b1;
    hold_req       = 0;

    fill_sine_table();
    phase_acc = '0;
    frame_pos = '0;
    step_reg  = PHASE_STEP_RESET;
    chan_reg  = CHANNEL_COUNT_RESET;
    flen_reg  = FRAME_LENGTH_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_quarter_points();
    test_channel_limits();
    test_frame_shrink();
    test_backpressure();
    test_random_settings();

    // let everything drain, then watch a while for stray transfers
    wait_drained();
    repeat (20) @(negedge clk);

    $display("Covered %0d ticks (%0d restarts), %0d channel copies checked, %0d register writes.",
             ticks_sent, restarts_sent, copies_checked, reg_writes);
    $display("Settings swept: phase step extremes, 0..15 channels, frame length 0..4095, stalls.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
